// ===== sv/assert_macros.svh =====
// Assertion helpers used by the composer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hjc_pkg.sv =====
package hjc_pkg;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_BACK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] KIND_PASS   = 2'd0;
    localparam logic [1:0] KIND_COMP   = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] PH_EMPTY   = 2'd0;
    localparam logic [1:0] PH_INITIAL = 2'd1;
    localparam logic [1:0] PH_MEDIAL  = 2'd2;
    localparam logic [1:0] PH_FINAL   = 2'd3;

    localparam logic [4:0] NONE_IDX = 5'd31;
    localparam int FIFO_DEPTH = 2;

    // Classified operation handed from the front to the back.
    localparam logic [1:0] OP_IGNORE = 2'd0;
    localparam logic [1:0] OP_CONS   = 2'd1;
    localparam logic [1:0] OP_VOWEL  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] cmd;
        logic [4:0] idx;
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] comp;
    } res_t;

    function automatic logic [4:0] cho_as_final(input logic [4:0] c);
        case (c)
            5'd0: return 5'd1;   5'd1: return 5'd2;   5'd2: return 5'd4;
            5'd3: return 5'd7;   5'd5: return 5'd8;   5'd6: return 5'd16;
            5'd7: return 5'd17;  5'd9: return 5'd19;  5'd10: return 5'd20;
            5'd11: return 5'd21; 5'd12: return 5'd22; 5'd14: return 5'd23;
            5'd15: return 5'd24; 5'd16: return 5'd25; 5'd17: return 5'd26;
            5'd18: return 5'd27;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] final_as_cho(input logic [4:0] f);
        case (f)
            5'd2: return 5'd1;   5'd4: return 5'd2;   5'd7: return 5'd3;
            5'd8: return 5'd5;   5'd16: return 5'd6;  5'd17: return 5'd7;
            5'd19: return 5'd9;  5'd20: return 5'd10; 5'd21: return 5'd11;
            5'd22: return 5'd12; 5'd23: return 5'd14; 5'd24: return 5'd15;
            5'd25: return 5'd16; 5'd26: return 5'd17; 5'd27: return 5'd18;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] split_keep(input logic [4:0] f);
        case (f)
            5'd3: return 5'd1;
            5'd5, 5'd6: return 5'd4;
            5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: return 5'd8;
            5'd18: return 5'd17;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] split_move(input logic [4:0] f);
        case (f)
            5'd3: return 5'd9;   5'd5: return 5'd12;  5'd6: return 5'd18;
            5'd10: return 5'd6;  5'd11: return 5'd7;  5'd12: return 5'd9;
            5'd13: return 5'd16; 5'd14: return 5'd17; 5'd15: return 5'd18;
            5'd18: return 5'd9;
            default: return 5'd0;
        endcase
    endfunction

    // Final cluster of a kept final and a following consonant, zero if none.
    function automatic logic [4:0] merge_final(input logic [4:0] f, input logic [4:0] c);
        case ({f, c})
            {5'd1, 5'd9}: return 5'd3;
            {5'd4, 5'd12}: return 5'd5;
            {5'd4, 5'd18}: return 5'd6;
            {5'd8, 5'd0}: return 5'd9;
            {5'd8, 5'd6}: return 5'd10;
            {5'd8, 5'd7}: return 5'd11;
            {5'd8, 5'd9}: return 5'd12;
            {5'd8, 5'd16}: return 5'd13;
            {5'd8, 5'd17}: return 5'd14;
            {5'd8, 5'd18}: return 5'd15;
            {5'd17, 5'd9}: return 5'd18;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] merge_vowel(input logic [4:0] a, input logic [4:0] b);
        case ({a, b})
            {5'd8, 5'd0}: return 5'd9;
            {5'd8, 5'd1}: return 5'd10;
            {5'd8, 5'd20}: return 5'd11;
            {5'd13, 5'd4}: return 5'd14;
            {5'd13, 5'd5}: return 5'd15;
            {5'd13, 5'd20}: return 5'd16;
            {5'd18, 5'd20}: return 5'd19;
            default: return NONE_IDX;
        endcase
    endfunction

    function automatic logic [4:0] vowel_first(input logic [4:0] v);
        case (v)
            5'd9, 5'd10, 5'd11: return 5'd8;
            5'd14, 5'd15, 5'd16: return 5'd13;
            5'd19: return 5'd18;
            default: return NONE_IDX;
        endcase
    endfunction

    function automatic logic [15:0] compat_cho(input logic [4:0] c);
        case (c)
            5'd0: return 16'h3131;  5'd1: return 16'h3132;  5'd2: return 16'h3134;
            5'd3: return 16'h3137;  5'd4: return 16'h3138;  5'd5: return 16'h3139;
            5'd6: return 16'h3141;  5'd7: return 16'h3142;  5'd8: return 16'h3143;
            5'd9: return 16'h3145;  5'd10: return 16'h3146; 5'd11: return 16'h3147;
            5'd12: return 16'h3148; 5'd13: return 16'h3149; 5'd14: return 16'h314A;
            5'd15: return 16'h314B; 5'd16: return 16'h314C; 5'd17: return 16'h314D;
            5'd18: return 16'h314E;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] compat_final(input logic [4:0] f);
        case (f)
            5'd1: return 16'h3131;  5'd2: return 16'h3132;  5'd3: return 16'h3133;
            5'd4: return 16'h3134;  5'd5: return 16'h3135;  5'd6: return 16'h3136;
            5'd7: return 16'h3137;  5'd8: return 16'h3139;  5'd9: return 16'h313A;
            5'd10: return 16'h313B; 5'd11: return 16'h313C; 5'd12: return 16'h313D;
            5'd13: return 16'h313E; 5'd14: return 16'h313F; 5'd15: return 16'h3140;
            5'd16: return 16'h3141; 5'd17: return 16'h3142; 5'd18: return 16'h3144;
            5'd19: return 16'h3145; 5'd20: return 16'h3146; 5'd21: return 16'h3147;
            5'd22: return 16'h3148; 5'd23: return 16'h314A; 5'd24: return 16'h314B;
            5'd25: return 16'h314C; 5'd26: return 16'h314D; 5'd27: return 16'h314E;
            default: return 16'h0000;
        endcase
    endfunction

    // Precomposed syllable; indices out of range give zero.
    function automatic logic [15:0] syllable(input logic [4:0] c, input logic [4:0] v,
                                             input logic [4:0] f);
        logic [15:0] cv;
        cv = 16'(c) * 16'd21 + 16'(v);
        if (c > 5'd18 || v > 5'd20 || f > 5'd27) return 16'h0000;
        return 16'hAC00 + 16'(cv * 16'd28) + 16'(f);
    endfunction

    function automatic logic [15:0] vowel_compat(input logic [4:0] v);
        return (v <= 5'd20) ? 16'h314F + 16'(v) : 16'h0000;
    endfunction

endpackage

// ===== sv/hjc_front.sv =====
module hjc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [5:0]        consonant_index,
    input  logic [5:0]        vowel_index,
    output logic              q_valid,
    input  logic              q_ready,
    output hjc_pkg::op_t      q_op
);

    localparam int PW = $clog2(hjc_pkg::FIFO_DEPTH);

    hjc_pkg::op_t    mem_reg [hjc_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    hjc_pkg::op_t    op;
    logic            cons_ok, vow_ok, push, pop;

    // Classify the command and the key indices.
    always_comb begin
        cons_ok = consonant_index <= 6'd18;
        vow_ok  = vowel_index <= 6'd20;
        op.cmd  = command;
        op.idx  = cons_ok ? consonant_index[4:0] : vowel_index[4:0];
        if (command != hjc_pkg::CMD_KEY || cons_ok == vow_ok) begin
            op.op = hjc_pkg::OP_IGNORE;
        end else if (cons_ok) begin
            op.op = hjc_pkg::OP_CONS;
        end else begin
            op.op = hjc_pkg::OP_VOWEL;
        end
    end

    assign in_ready = cnt_reg != (PW+1)'(hjc_pkg::FIFO_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_op     = mem_reg[rd_reg];

    // Queue pointers.
    always_comb begin
        wr_next  = push ? PW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? PW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= op;
        end
    end

endmodule

// ===== sv/hjc_back.sv =====
module hjc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  hjc_pkg::op_t  q_op,
    output logic          out_valid,
    input  logic          out_ready,
    output hjc_pkg::res_t out_res,
    output logic [1:0]    phase
);

    logic [1:0] ph_reg, ph_next;
    logic [4:0] ini_reg, ini_next, med_reg, med_next, fin_reg, fin_next;
    logic       ov_reg;
    hjc_pkg::res_t res_reg, r;
    logic [1:0] nph;
    logic [4:0] ni, nm, nf, x, k, cho;
    logic [15:0] sh, c;
    logic       go;

    assign q_ready   = !ov_reg || out_ready;
    assign go        = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign phase     = ph_reg;

    // Apply one command to the composition state.
    always_comb begin
        ph_next = ph_reg; ini_next = ini_reg; med_next = med_reg; fin_next = fin_reg;
        c = '0; x = '0; k = '0;
        cho = q_op.idx;
        r.kind = hjc_pkg::KIND_PASS; r.c1 = '0; r.c2 = '0;
        if (q_op.op == hjc_pkg::OP_CONS || q_op.op == hjc_pkg::OP_VOWEL) begin
            r.kind = hjc_pkg::KIND_COMP;
            case (ph_reg)
                hjc_pkg::PH_EMPTY: begin
                    if (q_op.op == hjc_pkg::OP_CONS) begin
                        ini_next = cho; ph_next = hjc_pkg::PH_INITIAL;
                    end else begin
                        r.kind = hjc_pkg::KIND_END; r.c1 = hjc_pkg::vowel_compat(cho);
                    end
                end
                hjc_pkg::PH_INITIAL: begin
                    if (q_op.op == hjc_pkg::OP_VOWEL) begin
                        if (fin_reg != '0 && fin_reg < 5'd28) begin
                            r.kind = hjc_pkg::KIND_COMMIT;
                            r.c1 = hjc_pkg::compat_final(hjc_pkg::split_keep(fin_reg));
                            ini_next = hjc_pkg::split_move(fin_reg);
                        end
                        med_next = cho; fin_next = '0; ph_next = hjc_pkg::PH_MEDIAL;
                    end else if (fin_reg != '0) begin
                        x = hjc_pkg::merge_final(fin_reg, cho);
                        if (x != '0) begin
                            fin_next = x;
                        end else begin
                            r.kind = hjc_pkg::KIND_COMMIT;
                            r.c1 = hjc_pkg::compat_final(fin_reg);
                            ini_next = cho; fin_next = '0;
                        end
                    end else begin
                        x = (ini_reg <= 5'd18) ?
                            hjc_pkg::merge_final(hjc_pkg::cho_as_final(ini_reg), cho) : 5'd0;
                        if (x != '0) begin
                            fin_next = x;
                        end else begin
                            r.kind = hjc_pkg::KIND_COMMIT;
                            r.c1 = hjc_pkg::compat_cho(ini_reg);
                            ini_next = cho;
                        end
                    end
                end
                hjc_pkg::PH_MEDIAL: begin
                    if (q_op.op == hjc_pkg::OP_CONS) begin
                        x = hjc_pkg::cho_as_final(cho);
                        if (x != '0) begin
                            fin_next = x; ph_next = hjc_pkg::PH_FINAL;
                        end else begin
                            r.kind = hjc_pkg::KIND_COMMIT;
                            r.c1 = hjc_pkg::syllable(ini_reg, med_reg, 5'd0);
                            ini_next = cho; med_next = hjc_pkg::NONE_IDX; fin_next = '0;
                            ph_next = hjc_pkg::PH_INITIAL;
                        end
                    end else begin
                        x = hjc_pkg::merge_vowel(med_reg, cho);
                        if (x != hjc_pkg::NONE_IDX) begin
                            med_next = x;
                        end else begin
                            r.kind = hjc_pkg::KIND_END;
                            r.c1 = hjc_pkg::syllable(ini_reg, med_reg, 5'd0);
                            r.c2 = hjc_pkg::vowel_compat(cho);
                            ph_next = hjc_pkg::PH_EMPTY; ini_next = hjc_pkg::NONE_IDX;
                            med_next = hjc_pkg::NONE_IDX; fin_next = '0;
                        end
                    end
                end
                default: begin
                    if (q_op.op == hjc_pkg::OP_VOWEL) begin
                        k = hjc_pkg::split_keep(fin_reg);
                        r.kind = hjc_pkg::KIND_COMMIT;
                        r.c1 = hjc_pkg::syllable(ini_reg, med_reg, k);
                        ini_next = (k != '0) ? hjc_pkg::split_move(fin_reg)
                                             : hjc_pkg::final_as_cho(fin_reg);
                        med_next = cho; fin_next = '0; ph_next = hjc_pkg::PH_MEDIAL;
                    end else begin
                        x = hjc_pkg::merge_final(fin_reg, cho);
                        if (x != '0) begin
                            fin_next = x;
                        end else begin
                            r.kind = hjc_pkg::KIND_COMMIT;
                            r.c1 = hjc_pkg::syllable(ini_reg, med_reg, fin_reg);
                            ini_next = cho; med_next = hjc_pkg::NONE_IDX; fin_next = '0;
                            ph_next = hjc_pkg::PH_INITIAL;
                        end
                    end
                end
            endcase
        end else if (q_op.cmd == hjc_pkg::CMD_BACK) begin
            r.kind = hjc_pkg::KIND_COMP;
            case (ph_reg)
                hjc_pkg::PH_FINAL: begin
                    x = hjc_pkg::split_keep(fin_reg);
                    fin_next = x;
                    if (x == '0) ph_next = hjc_pkg::PH_MEDIAL;
                end
                hjc_pkg::PH_MEDIAL: begin
                    x = hjc_pkg::vowel_first(med_reg);
                    med_next = x;
                    if (x == hjc_pkg::NONE_IDX) ph_next = hjc_pkg::PH_INITIAL;
                end
                hjc_pkg::PH_INITIAL: begin
                    if (fin_reg != '0) begin
                        fin_next = '0;
                    end else begin
                        r.kind = hjc_pkg::KIND_END;
                        ph_next = hjc_pkg::PH_EMPTY; ini_next = hjc_pkg::NONE_IDX;
                        med_next = hjc_pkg::NONE_IDX;
                    end
                end
                default: r.kind = hjc_pkg::KIND_PASS;
            endcase
        end else if (q_op.cmd == hjc_pkg::CMD_FLUSH && ph_reg != hjc_pkg::PH_EMPTY) begin
            r.kind = hjc_pkg::KIND_END;
            r.c1 = c;
            ph_next = hjc_pkg::PH_EMPTY; ini_next = hjc_pkg::NONE_IDX;
            med_next = hjc_pkg::NONE_IDX; fin_next = '0;
        end
        // Flush commits whatever is shown now.
        nph = ph_reg; ni = ini_reg; nm = med_reg; nf = fin_reg;
        case (nph)
            hjc_pkg::PH_INITIAL: c = (nf != '0 && nf < 5'd28) ? hjc_pkg::compat_final(nf)
                                                              : hjc_pkg::compat_cho(ni);
            hjc_pkg::PH_MEDIAL:  c = hjc_pkg::syllable(ni, nm, 5'd0);
            hjc_pkg::PH_FINAL:   c = hjc_pkg::syllable(ni, nm, nf);
            default:             c = '0;
        endcase
        if (q_op.op == hjc_pkg::OP_IGNORE && q_op.cmd == hjc_pkg::CMD_FLUSH &&
            ph_reg != hjc_pkg::PH_EMPTY) begin
            r.c1 = c;
        end
        // Code point shown after the update.
        case (ph_next)
            hjc_pkg::PH_INITIAL:
                sh = (fin_next != '0 && fin_next < 5'd28) ? hjc_pkg::compat_final(fin_next)
                                                          : hjc_pkg::compat_cho(ini_next);
            hjc_pkg::PH_MEDIAL: sh = hjc_pkg::syllable(ini_next, med_next, 5'd0);
            hjc_pkg::PH_FINAL:  sh = hjc_pkg::syllable(ini_next, med_next, fin_next);
            default:            sh = '0;
        endcase
        r.comp = (r.kind == hjc_pkg::KIND_PASS || r.kind == hjc_pkg::KIND_END) ? 16'h0 : sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= hjc_pkg::PH_EMPTY;
            ini_reg <= hjc_pkg::NONE_IDX;
            med_reg <= hjc_pkg::NONE_IDX;
            fin_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (go) begin
                ph_reg  <= ph_next;
                ini_reg <= ini_next;
                med_reg <= med_next;
                fin_reg <= fin_next;
                ov_reg  <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg <= r;
        end
    end

endmodule

// ===== sv/hangul_jamo_composer_core.sv =====
// Hangul two-set composition core.
// Slave channel s_*: one command per transfer. tdata holds command [1:0],
// consonant_index [7:2] and vowel_index [13:8], padded to 16 bits.
// Master channel m_*: one result per command. tdata holds result_kind [1:0],
// first_commit [17:2], second_commit [33:18], composing_char [49:34],
// padded to 56 bits.
// A command passes a two-entry queue in the front, then the back applies it to
// the composition state and the table lookups combinationally and registers the
// result. The command goes from its queue entry to the result register, and a
// stalled receiver can hold it in the queue between the two.
// Throughput is one command per cycle while the receiver takes each result.
// When the receiver stalls, the result register holds, the queue fills, and
// s_tready drops once both entries are taken.
// Reset (aresetn low, synchronous) empties the queue, drops m_tvalid and
// clears the composition to the empty phase.
`include "assert_macros.svh"
module hangul_jamo_composer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command, consonant_index, vowel_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // result_kind, first, second, composing
);

    logic          q_valid, q_ready;
    hjc_pkg::op_t  q_op;
    hjc_pkg::res_t res;
    logic [1:0]    phase;

    hjc_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[1:0]), .consonant_index(s_tdata[7:2]),
        .vowel_index(s_tdata[13:8]),
        .q_valid, .q_ready, .q_op
    );

    hjc_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_op,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res), .phase
    );

    assign m_tdata = {6'd0, res.comp, res.c2, res.c1, res.kind};

    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ASSERT_IMPL(a_end_empty, aclk, aresetn, $rose(m_tvalid) && m_tdata[1:0] == hjc_pkg::KIND_END |-> phase == hjc_pkg::PH_EMPTY, "end result left composition open")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
